>>> hw/rtl/asf_pkg.sv
// ============================================================================
// asf_pkg
// Shared constants and Q16.16 arithmetic helpers for the advection stencil.
// ============================================================================
package asf_pkg;

    localparam int unsigned DataW    = 32;
    localparam int unsigned ColW     = 10;
    localparam int unsigned InvW     = 31;
    localparam int unsigned CfgAddrW = 3;
    localparam int unsigned InTdataW = 240;
    localparam int unsigned OutTdataW = 32;

    localparam logic [CfgAddrW-1:0] RegSchemeSelect     = 3'd0;
    localparam logic [CfgAddrW-1:0] RegLastColumn       = 3'd1;
    localparam logic [CfgAddrW-1:0] RegPecletShear      = 3'd2;
    localparam logic [CfgAddrW-1:0] RegPecletOscillatory = 3'd3;
    localparam logic [CfgAddrW-1:0] RegInverseSpacing   = 3'd4;

    localparam logic signed [DataW-1:0] QOne = 32'sh0001_0000;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'sh0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -48'sh0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // q16.16 multiply, floor rounding, saturated
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return sat32(p[63:16]);
    endfunction

    // half of the monotonized-central limited slope through (l, c, r)
    function automatic logic signed [32:0] half_mc(input logic signed [31:0] l,
                                                   input logic signed [31:0] c,
                                                   input logic signed [31:0] r);
        logic signed [32:0] dl;
        logic signed [32:0] dr;
        logic [32:0] al;
        logic [32:0] ar;
        logic [33:0] cen;
        logic [33:0] mn2;
        logic [33:0] lim;
        logic signed [32:0] res;
        dl = 33'(c) - 33'(l);
        dr = 33'(r) - 33'(c);
        al = dl[32] ? 33'(-dl) : 33'(dl);
        ar = dr[32] ? 33'(-dr) : 33'(dr);
        cen = ({1'b0, al} + {1'b0, ar}) >> 1;
        mn2 = (al < ar) ? {al, 1'b0} : {ar, 1'b0};
        lim = ((cen < mn2) ? cen : mn2) >> 1;
        if (dl == '0 || dr == '0 || (dl[32] != dr[32])) begin
            res = '0;
        end else if (dl[32]) begin
            res = -$signed(lim[32:0]);
        end else begin
            res = $signed(lim[32:0]);
        end
        return res;
    endfunction

endpackage

>>> hw/rtl/advection_flux_stencil.sv
// ============================================================================
// advection_flux_stencil
// Per-point advection term, donor-cell upwind or MC-limited TVD, Q16.16.
// ============================================================================
// usage:
//   s_ channel: one grid point per transfer, five x-neighbor concentrations,
//   y coordinate, flow term and column index packed in s_tdata.
//   m_ channel: one result transfer per input transfer, in order, carrying
//   the saturated Q16.16 advection term.
//   cfg port: single-cycle writes, index selects the register; write only
//   while no point is in flight.
// order: the input transfer edge loads the first of six register stages
//   (shear products, second product and face values, velocity sum, flux
//   products, upwind sum or flux difference, scale); m_tvalid is the last valid bit.
// throughput: one point per cycle while m_tready is high; each stage owns a valid
//   bit and advances when it is empty or the stage after it moves.
// reset: aresetn low clears all valid bits and loads the register defaults
//   (upwind, last column 1023, shear 1.0, oscillatory 0, spacing 1.0).
// stall: with m_tready low the last stage holds its result; earlier stages
//   keep filling bubbles, so s_tready drops only once the pipe is full.
// ============================================================================
module advection_flux_stencil (
    input  logic                               aclk,
    input  logic                               aresetn,
    // c_minus2, c_minus1, c_center, c_plus1, c_plus2, y_coord, flow_term,
    // column_index, zero fill
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [asf_pkg::InTdataW-1:0]       s_tdata,
    // adv_term
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [asf_pkg::OutTdataW-1:0]      m_tdata,
    input  logic                               cfg_we,
    input  logic [asf_pkg::CfgAddrW-1:0]       cfg_addr,
    input  logic [asf_pkg::DataW-1:0]          cfg_wdata
);

    // configuration registers
    logic                          scheme_reg;
    logic [asf_pkg::ColW-1:0]      last_col_reg;
    logic signed [31:0]            pe_shear_reg;
    logic signed [31:0]            pe_osc_reg;
    logic [asf_pkg::InvW-1:0]      inv_sp_reg;
    logic signed [31:0]            inv_s;

    assign inv_s = $signed({1'b0, inv_sp_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scheme_reg   <= 1'b0;
            last_col_reg <= 10'd1023;
            pe_shear_reg <= asf_pkg::QOne;
            pe_osc_reg   <= '0;
            inv_sp_reg   <= 31'(asf_pkg::QOne);
        end else if (cfg_we) begin
            case (cfg_addr)
                asf_pkg::RegSchemeSelect:      scheme_reg   <= cfg_wdata[0];
                asf_pkg::RegLastColumn:        last_col_reg <= cfg_wdata[9:0];
                asf_pkg::RegPecletShear:       pe_shear_reg <= $signed(cfg_wdata);
                asf_pkg::RegPecletOscillatory: pe_osc_reg   <= $signed(cfg_wdata);
                asf_pkg::RegInverseSpacing:    inv_sp_reg   <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    // input unpacking
    logic signed [31:0] cm2, cm1, c0, cp1, cp2, yv, ff;
    logic [asf_pkg::ColW-1:0] col;
    assign cm2 = $signed(s_tdata[31:0]);
    assign cm1 = $signed(s_tdata[63:32]);
    assign c0  = $signed(s_tdata[95:64]);
    assign cp1 = $signed(s_tdata[127:96]);
    assign cp2 = $signed(s_tdata[159:128]);
    assign yv  = $signed(s_tdata[191:160]);
    assign ff  = $signed(s_tdata[223:192]);
    assign col = s_tdata[233:224];

    // per-stage valid and advance
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic en1, en2, en3, en4, en5, en6;

    assign en6 = !v6_reg || m_tready;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
        end
    end

    // stage 1: first velocity products, limited slopes, upwind differences
    logic signed [31:0] p1_reg, om_reg, p2_reg;
    logic signed [32:0] hm_reg, h0_reg, hp_reg;
    logic               fm_reg, f0_reg, fp_reg;
    logic signed [31:0] bd_reg, fd_reg, cm1_1_reg, c0_1_reg, cp1_1_reg;
    logic               f0_next, fm_next, fp_next;

    // slope at i needs 0 < i < nx, at i-1 needs i >= 2, at i+1 needs i+2 <= nx
    assign f0_next = (col != '0) && (col < last_col_reg);
    assign fm_next = (col >= 10'd2);
    assign fp_next = ({1'b0, col} + 11'd2) <= {1'b0, last_col_reg};

    always_ff @(posedge aclk) begin
        if (en1) begin
            p1_reg    <= asf_pkg::qmul(pe_shear_reg, yv);
            om_reg    <= asf_pkg::sat32(48'(asf_pkg::QOne) - 48'(yv));
            p2_reg    <= asf_pkg::qmul(pe_osc_reg, ff);
            hm_reg    <= asf_pkg::half_mc(cm2, cm1, c0);
            h0_reg    <= asf_pkg::half_mc(cm1, c0, cp1);
            hp_reg    <= asf_pkg::half_mc(c0, cp1, cp2);
            fm_reg    <= fm_next;
            f0_reg    <= f0_next;
            fp_reg    <= fp_next;
            bd_reg    <= asf_pkg::sat32(48'(c0) - 48'(cm1));
            fd_reg    <= asf_pkg::sat32(48'(cp1) - 48'(c0));
            cm1_1_reg <= cm1;
            c0_1_reg  <= c0;
            cp1_1_reg <= cp1;
        end
    end

    // stage 2: shear product, scaled differences, candidate face values
    logic signed [31:0] p3_reg, p2_2_reg, back_reg, fwd_reg;
    logic signed [31:0] rvp_reg, lvp_reg, rvn_reg, lvn_reg;

    always_ff @(posedge aclk) begin
        if (en2) begin
            p3_reg   <= asf_pkg::qmul(p1_reg, om_reg);
            p2_2_reg <= p2_reg;
            back_reg <= asf_pkg::qmul(bd_reg, inv_s);
            fwd_reg  <= asf_pkg::qmul(fd_reg, inv_s);
            rvp_reg  <= f0_reg ? asf_pkg::sat32(48'(c0_1_reg) + 48'(h0_reg)) : c0_1_reg;
            lvp_reg  <= fm_reg ? asf_pkg::sat32(48'(cm1_1_reg) + 48'(hm_reg)) : cm1_1_reg;
            rvn_reg  <= fp_reg ? asf_pkg::sat32(48'(cp1_1_reg) - 48'(hp_reg)) : cp1_1_reg;
            lvn_reg  <= f0_reg ? asf_pkg::sat32(48'(c0_1_reg) - 48'(h0_reg)) : c0_1_reg;
        end
    end

    // stage 3: velocity
    logic signed [31:0] du_reg, back3_reg, fwd3_reg, rvp3_reg, lvp3_reg, rvn3_reg, lvn3_reg;

    always_ff @(posedge aclk) begin
        if (en3) begin
            du_reg    <= asf_pkg::sat32(48'(p3_reg) + 48'(p2_2_reg));
            back3_reg <= back_reg;
            fwd3_reg  <= fwd_reg;
            rvp3_reg  <= rvp_reg;
            lvp3_reg  <= lvp_reg;
            rvn3_reg  <= rvn_reg;
            lvn3_reg  <= lvn_reg;
        end
    end

    // stage 4: flux products, branch on velocity sign (zero goes positive)
    logic signed [31:0] m1_reg, m2_reg;
    logic signed [31:0] m1_next, m2_next, pos_du, neg_du, rv, lv;

    always_comb begin
        pos_du = du_reg[31] ? '0 : du_reg;
        neg_du = du_reg[31] ? du_reg : '0;
        rv     = du_reg[31] ? rvn3_reg : rvp3_reg;
        lv     = du_reg[31] ? lvn3_reg : lvp3_reg;
        if (scheme_reg) begin
            m1_next = asf_pkg::qmul(du_reg, rv);
            m2_next = asf_pkg::qmul(du_reg, lv);
        end else begin
            m1_next = asf_pkg::qmul(pos_du, back3_reg);
            m2_next = asf_pkg::qmul(neg_du, fwd3_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            m1_reg <= m1_next;
            m2_reg <= m2_next;
        end
    end

    // stage 5: upwind sum or flux difference
    logic signed [31:0] r5_reg;

    always_ff @(posedge aclk) begin
        if (en5) begin
            r5_reg <= scheme_reg ? asf_pkg::sat32(48'(m1_reg) - 48'(m2_reg))
                                 : asf_pkg::sat32(48'(m1_reg) + 48'(m2_reg));
        end
    end

    // stage 6: scale by inverse spacing in tvd mode, output register
    logic signed [31:0] res_reg;

    always_ff @(posedge aclk) begin
        if (en6) begin
            res_reg <= scheme_reg ? asf_pkg::qmul(r5_reg, inv_s) : r5_reg;
        end
    end

    assign m_tvalid = v6_reg;
    assign m_tdata  = res_reg;

endmodule

>>> hw/rtl/asf_checker.sv
// ============================================================================
// asf_checker
// Port-level checks for the advection stencil pipeline.
// ============================================================================
module asf_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [asf_pkg::OutTdataW-1:0]  m_tdata
);

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // an accepting sink lets every stage advance
    a_ready_through: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("s_tready low while m_tready high");

    // an empty output stage never blocks the input
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("s_tready low with empty output stage");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");

endmodule

bind advection_flux_stencil asf_checker u_asf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> test/tb_advection_flux_stencil.sv
// ============================================================================
// tb_advection_flux_stencil
// Self-checking bench for the advection stencil: predicts each Q16.16 result
// in upwind and TVD modes, checks results in order under random stalls.
// ============================================================================

// in-order store of predicted advection terms
class adv_scoreboard;
    logic [31:0] pending_terms[$];
    int unsigned mismatches;

    function void note_point(input logic [31:0] term);
        pending_terms.push_back(term);
    endfunction

    function void check_term(input logic [31:0] got);
        logic [31:0] want;
        if (pending_terms.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected result transfer: adv_term %h", got);
            end
        end else begin
            want = pending_terms.pop_front();
            if (want !== got) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("adv_term mismatch: expected %h actual %h", want, got);
                end
            end
        end
    endfunction
endclass

module tb_advection_flux_stencil;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [asf_pkg::InTdataW-1:0]  s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [asf_pkg::OutTdataW-1:0] m_tdata;
    logic                          cfg_we = 1'b0;
    logic [asf_pkg::CfgAddrW-1:0]  cfg_addr = '0;
    logic [asf_pkg::DataW-1:0]     cfg_wdata = '0;

    // idle rates in percent, zero during the no-idle stretch
    int unsigned send_idle_pct = 7;
    int unsigned recv_idle_pct = 7;

    adv_scoreboard sb;

    // local copy of the configuration registers
    logic        mdl_tvd;
    logic [9:0]  mdl_last_col;
    logic signed [31:0] mdl_shear;
    logic signed [31:0] mdl_osc;
    logic [30:0] mdl_inv;

    advection_flux_stencil DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always #6 aclk = ~aclk;

    // ---------------------------------------------------------------- arithmetic
    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF) begin
            return 64'sh7FFF_FFFF;
        end
        if (v < -64'sh8000_0000) begin
            return -64'sh8000_0000;
        end
        return v;
    endfunction

    // q16.16 product, floor, clamped
    function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [63:0] p;
        p = a * b;
        return clamp32(p >>> 16);
    endfunction

    // half the monotonized-central slope
    function automatic logic signed [63:0] mc_half(input logic signed [63:0] l,
                                                   input logic signed [63:0] c,
                                                   input logic signed [63:0] r);
        logic signed [63:0] dl, dr, al, ar, cen, mn, lim;
        dl = c - l;
        dr = r - c;
        if (dl == 0 || dr == 0 || ((dl < 0) != (dr < 0))) begin
            return 0;
        end
        al = (dl < 0) ? -dl : dl;
        ar = (dr < 0) ? -dr : dr;
        cen = (al + ar) >>> 1;
        mn = (al < ar) ? al : ar;
        lim = (cen < 2 * mn) ? cen : 2 * mn;
        lim = lim >>> 1;
        return (dl < 0) ? -lim : lim;
    endfunction

    // predicted advection term for one grid point
    function automatic logic [31:0] advection_term(input logic [31:0] f[7],
                                                   input logic [9:0] col);
        logic signed [63:0] cm2, cm1, c0, cp1, cp2, y, ff, du, res, rv, lv;
        logic signed [63:0] inv, nx, i, back, fwd;
        cm2 = $signed(f[0]); cm1 = $signed(f[1]); c0 = $signed(f[2]);
        cp1 = $signed(f[3]); cp2 = $signed(f[4]); y = $signed(f[5]);
        ff = $signed(f[6]);
        inv = {33'd0, mdl_inv};
        nx = {54'd0, mdl_last_col};
        i = {54'd0, col};
        du = clamp32(fx_mul(fx_mul(mdl_shear, y), clamp32(64'sd65536 - y))
                     + fx_mul(mdl_osc, ff));
        if (!mdl_tvd) begin
            back = fx_mul(clamp32(c0 - cm1), inv);
            fwd = fx_mul(clamp32(cp1 - c0), inv);
            res = clamp32(fx_mul((du > 0) ? du : 0, back)
                          + fx_mul((du < 0) ? du : 0, fwd));
        end else begin
            if (du >= 0) begin
                rv = c0;
                if (i > 0 && i < nx) rv = clamp32(rv + mc_half(cm1, c0, cp1));
                lv = cm1;
                if (i >= 2) lv = clamp32(lv + mc_half(cm2, cm1, c0));
            end else begin
                rv = cp1;
                if (i <= nx - 2) rv = clamp32(rv - mc_half(c0, cp1, cp2));
                lv = c0;
                if (i > 0 && i < nx) lv = clamp32(lv - mc_half(cm1, c0, cp1));
            end
            res = fx_mul(clamp32(fx_mul(du, rv) - fx_mul(du, lv)), inv);
        end
        return res[31:0];
    endfunction

    // ---------------------------------------------------------------- drivers
    task automatic write_reg(input logic [asf_pkg::CfgAddrW-1:0] idx,
                             input logic [31:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            asf_pkg::RegSchemeSelect:      mdl_tvd = val[0];
            asf_pkg::RegLastColumn:        mdl_last_col = val[9:0];
            asf_pkg::RegPecletShear:       mdl_shear = val;
            asf_pkg::RegPecletOscillatory: mdl_osc = val;
            asf_pkg::RegInverseSpacing:    mdl_inv = val[30:0];
            default: ;
        endcase
    endtask

    // one point transfer; valid held across back-to-back points
    task automatic send_point(input logic [31:0] f[7], input logic [9:0] col);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, col, f[6], f[5], f[4], f[3], f[2], f[1], f[0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_point(advection_term(f, col));
        @(negedge aclk);
    endtask

    task automatic end_burst();
        s_tvalid <= 1'b0;
    endtask

    // wait out the pipe so config writes see an idle block
    task automatic drain();
        int unsigned n;
        end_burst();
        n = 0;
        while (sb.pending_terms.size() != 0 && n < 200000) begin
            @(negedge aclk);
            n++;
        end
        repeat (12) @(negedge aclk);
    endtask

    // ---------------------------------------------------------------- receiver
    always @(negedge aclk) begin
        if (aresetn) begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_term(m_tdata);
        end
    end

    // ---------------------------------------------------------------- stimulus
    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
            3: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_points(input int unsigned count);
        logic [31:0] f[7];
        logic [31:0] base;
        logic [9:0] col;
        for (int unsigned k = 0; k < count; k++) begin
            if ($urandom_range(3) == 0) begin
                foreach (f[j]) f[j] = pick_value();
            end else begin
                // smooth or stepped profiles exercise the limiter branches
                base = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
                for (int j = 0; j < 5; j++) begin
                    f[j] = base + ($urandom_range(0, 32'h0000_8000) - 32'h0000_4000);
                    base = f[j] + (($urandom_range(1) == 0) ? 32'h1000 : -32'h1000);
                end
                f[5] = $urandom_range(0, 32'h0001_4000) - 32'h0000_2000;
                f[6] = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
            end
            col = ($urandom_range(3) == 0) ? 10'($urandom_range(0, 3))
                : (($urandom_range(3) == 0) ? mdl_last_col - 10'($urandom_range(0, 3))
                : 10'($urandom));
            send_point(f, col);
        end
    endtask

    initial begin
        logic [31:0] f[7];
        sb = new();
        mdl_tvd = 1'b0;
        mdl_last_col = 10'd1023;
        mdl_shear = 32'sh0001_0000;
        mdl_osc = 32'sd0;
        mdl_inv = 31'h0001_0000;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: extremes, both schemes, edge columns, zero velocity
        for (int m = 0; m < 2; m++) begin
            write_reg(asf_pkg::RegSchemeSelect, m);
            write_reg(asf_pkg::RegLastColumn, 32'd5);
            foreach (f[j]) f[j] = 32'h7FFF_FFFF;
            send_point(f, 10'd0);
            foreach (f[j]) f[j] = 32'h8000_0000;
            send_point(f, 10'h3FF);
            f = '{32'h0, 32'h1_0000, 32'h3_0000, 32'h4_0000, 32'h8_0000,
                  32'h0000_8000, 32'h0};
            send_point(f, 10'd1);
            send_point(f, 10'd3);
            send_point(f, 10'd5);
            f[5] = 32'h0002_0000;          // negative velocity
            send_point(f, 10'd2);
            send_point(f, 10'd4);
            f[5] = 32'h0001_0000;          // zero velocity
            send_point(f, 10'd2);
            f = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF};
            send_point(f, 10'd2);
            drain();
        end

        // config sweep, extremes included
        write_reg(asf_pkg::RegPecletOscillatory, 32'h0001_8000);
        write_reg(asf_pkg::RegInverseSpacing, 32'h7FFF_FFFF);
        write_reg(asf_pkg::RegLastColumn, 32'd2);
        random_points(120);
        drain();
        write_reg(asf_pkg::RegSchemeSelect, 32'd0);
        write_reg(asf_pkg::RegPecletShear, 32'h8000_0000);
        write_reg(asf_pkg::RegPecletOscillatory, 32'h7FFF_FFFF);
        write_reg(asf_pkg::RegInverseSpacing, 32'h0);
        write_reg(asf_pkg::RegLastColumn, 32'd0);
        random_points(100);
        drain();
        write_reg(asf_pkg::RegInverseSpacing, 32'h8002_0000);
        write_reg(asf_pkg::RegPecletShear, 32'h0004_0000);
        write_reg(asf_pkg::RegPecletOscillatory, 32'hFFFF_0000);
        random_points(200);
        drain();
        // no idling on either side for a long stretch
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(asf_pkg::RegSchemeSelect, 32'd1);
        write_reg(asf_pkg::RegLastColumn, 32'd1023);
        random_points(300);
        send_idle_pct = 7;
        recv_idle_pct = 7;
        drain();
        write_reg(asf_pkg::RegLastColumn, 32'd17);
        write_reg(asf_pkg::RegInverseSpacing, 32'h0000_4000);
        write_reg(asf_pkg::RegPecletShear, 32'h7FFF_FFFF);
        random_points(150);
        drain();
        write_reg(asf_pkg::RegPecletShear, 32'h0001_0000);
        write_reg(asf_pkg::RegPecletOscillatory, 32'h0);
        write_reg(asf_pkg::RegInverseSpacing, 32'h0001_0000);
        random_points(210);
        drain();

        if (sb.mismatches == 0 && sb.pending_terms.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog, far past the slowest legal run
    initial begin
        #3000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

>>> sim.f
hw/rtl/asf_pkg.sv
hw/rtl/advection_flux_stencil.sv
hw/rtl/asf_checker.sv
test/tb_advection_flux_stencil.sv
